[hw/rtl/wildcard_byte_signature_scan_defines.svh]
// ---------------------------------------------------------------------------
// wildcard byte signature scan assertion macros
// concurrent checks on clk_i, switched off when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef WILDCARD_BYTE_SIGNATURE_SCAN_DEFINES_SVH
`define WILDCARD_BYTE_SIGNATURE_SCAN_DEFINES_SVH

`ifndef SYNTH
`define WBSS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wbss assertion failed");
`else
`define WBSS_ASSERT_IMPL(lbl, ante, cons)
`endif

`ifndef SYNTH
`define WBSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wbss assertion failed");
`else
`define WBSS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[hw/rtl/wbss_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wbss_pkg
// shared types, constants and helpers of the wildcard byte signature scan
// ---------------------------------------------------------------------------
package wbss_pkg;

  localparam int MAX_PATTERN_BYTES = 16;
  localparam int PATTERN_SLOTS     = 16;
  localparam int SPAN_W            = $clog2(PATTERN_SLOTS);
  localparam int LIMIT_BYTES       = (MAX_PATTERN_BYTES > PATTERN_SLOTS) ?
                                     PATTERN_SLOTS : MAX_PATTERN_BYTES;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_BASE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_FIRST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LAST  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CARE_MASK     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RELATIVE      = 3'd5;

  localparam logic [31:0] DISP_OFFSET = 32'd3;
  localparam logic [2:0]  DISP_BYTES  = 3'd4;
  localparam logic [63:0] DISP_ADJUST = 64'd7;

  typedef enum logic [1:0] {
    ST_NOT_FOUND = 2'd0,
    ST_FOUND     = 2'd1,
    ST_CUT       = 2'd2
  } status_e;

  typedef struct packed {
    logic [63:0] image_base;
    logic [63:0] pattern_first;
    logic [63:0] pattern_last;
    logic [15:0] care_mask;
    logic [4:0]  pattern_length;
    logic        relative_mode;
  } cfg_t;

  typedef struct packed {
    status_e     status;
    logic        resolve;
    logic [31:0] pos;
    logic [31:0] disp;
  } event_t;

  // pattern length clamped to 1..LIMIT_BYTES, minus one
  function automatic logic [SPAN_W-1:0] span_of(input logic [4:0] len);
    logic [SPAN_W-1:0] s;
    if (len == 5'd0) begin
      s = '0;
    end else if (len > 5'(LIMIT_BYTES)) begin
      s = SPAN_W'(LIMIT_BYTES - 1);
    end else begin
      s = SPAN_W'(len - 5'd1);
    end
    return s;
  endfunction

  function automatic logic [7:0] pattern_byte(input logic [63:0] first,
                                              input logic [63:0] last,
                                              input logic [SPAN_W-1:0] k);
    logic [7:0] b;
    if (k[3]) begin
      b = last[{k[2:0], 3'b000} +: 8];
    end else begin
      b = first[{k[2:0], 3'b000} +: 8];
    end
    return b;
  endfunction

endpackage

[hw/rtl/wildcard_byte_signature_scan.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wildcard_byte_signature_scan
// streams image bytes through a chain of compare cells and reports the first
// masked pattern match, optionally resolving a relative 32-bit displacement
// ---------------------------------------------------------------------------
// throughput: one byte per cycle while the event register is empty or being
// taken, set by the shift and masked compare across the cell chain
// a result passes the event register, then address resolution into the
// output register
// reset: scan state and window cleared at once, registers to their defaults
// (care mask all ones, pattern length one), no clearing pass
module wildcard_byte_signature_scan
  import wbss_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [7:0]            s_axis_tdata_i,  // [7:0] data_byte
  input  logic                  s_axis_tlast_i,  // end_of_image
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [63:0]           m_axis_tdata_o,  // [63:0] match_address
  output logic [1:0]            m_axis_tuser_o   // [1:0] status
);

  cfg_t   cfg_q, cfg_d;
  logic   ev_valid, ev_ready;
  event_t ev;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_IMAGE_BASE:    cfg_d.image_base     = cfg_wdata_i;
        REG_PATTERN_FIRST: cfg_d.pattern_first  = cfg_wdata_i;
        REG_PATTERN_LAST:  cfg_d.pattern_last   = cfg_wdata_i;
        REG_CARE_MASK:     cfg_d.care_mask      = cfg_wdata_i[15:0];
        REG_PATTERN_LEN:   cfg_d.pattern_length = cfg_wdata_i[4:0];
        REG_RELATIVE:      cfg_d.relative_mode  = cfg_wdata_i[0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{image_base: 64'd0, pattern_first: 64'd0, pattern_last: 64'd0,
                 care_mask: 16'hFFFF, pattern_length: 5'd1, relative_mode: 1'b0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  wbss_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_byte_i  (s_axis_tdata_i),
    .in_last_i  (s_axis_tlast_i),
    .ev_valid_o (ev_valid),
    .ev_ready_i (ev_ready),
    .ev_o       (ev)
  );

  wbss_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .image_base_i (cfg_q.image_base),
    .ev_valid_i   (ev_valid),
    .ev_ready_o   (ev_ready),
    .ev_i         (ev),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_status_o (m_axis_tuser_o),
    .out_addr_o   (m_axis_tdata_o)
  );

endmodule

[hw/rtl/wbss_cell.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wbss_cell
// one window byte: shifts from its neighbor and compares the incoming byte
// ---------------------------------------------------------------------------
module wbss_cell
  import wbss_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       shift_i,
  input  logic       clear_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] pat_i,
  input  logic       care_i,
  output logic [7:0] byte_o,
  output logic       hit_o
);

  logic [7:0] byte_q, byte_d;

  always_comb begin
    byte_d = byte_q;
    if (clear_i) begin
      byte_d = '0;
    end else if (shift_i) begin
      byte_d = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

  // compare against the value the cell takes on this shift
  assign hit_o  = !care_i || (byte_i == pat_i);
  assign byte_o = byte_q;

endmodule

[hw/rtl/wbss_scan.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wbss_scan
// cell chain, match tracking, displacement gathering and the event register
// ---------------------------------------------------------------------------
`include "wildcard_byte_signature_scan_defines.svh"

module wbss_scan
  import wbss_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       ev_valid_o,
  input  logic       ev_ready_i,
  output event_t     ev_o
);

  logic [SPAN_W-1:0] span;
  logic [31:0]       span_ext;
  logic              s_fire;

  logic [7:0] win_in  [PATTERN_SLOTS];
  logic [7:0] win_out [PATTERN_SLOTS];
  logic [PATTERN_SLOTS-1:0] hit;

  logic [31:0] pos_q, pos_d;
  logic        seen_q, seen_d;
  logic [31:0] mpos_q, mpos_d;
  logic [2:0]  taken_q, taken_d;
  logic [31:0] disp_q, disp_d;
  logic        answered_q, answered_d;
  logic        ev_valid_q, ev_valid_d;
  event_t      ev_q, ev_d;

  logic [31:0] since_match;
  logic [3:0]  pre_ok;
  logic [31:0] pre_val;
  logic [2:0]  pre_cnt;

  logic        seen_n, ans_n, emit;
  logic [31:0] mpos_n, disp_n;
  logic [2:0]  taken_n;
  event_t      ev_n;

  assign span       = span_of(cfg_i.pattern_length);
  assign span_ext   = 32'(span);
  assign in_ready_o = !ev_valid_q || ev_ready_i;
  assign s_fire     = in_valid_i && in_ready_o;

  for (genvar w = 0; w < PATTERN_SLOTS; w++) begin : g_cell
    logic [SPAN_W-1:0] k;
    logic              used;
    if (w == 0) begin : g_head
      assign win_in[w] = in_byte_i;
    end else begin : g_link
      assign win_in[w] = win_out[w-1];
    end
    // cell w lines up with pattern byte span - w
    assign k    = span - SPAN_W'(w);
    assign used = (SPAN_W'(w) <= span);
    wbss_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (s_fire),
      .clear_i (s_fire && in_last_i),
      .byte_i  (win_in[w]),
      .pat_i   (pattern_byte(cfg_i.pattern_first, cfg_i.pattern_last, k)),
      .care_i  (used && cfg_i.care_mask[k]),
      .byte_o  (win_out[w]),
      .hit_o   (hit[w])
    );
  end

  // displacement bytes already in the window when the match is found
  for (genvar t = 0; t < 4; t++) begin : g_pre
    assign pre_ok[t] = (span >= SPAN_W'(3 + t));
    assign pre_val[8*t +: 8] = pre_ok[t] ? win_in[span - SPAN_W'(3 + t)] : 8'd0;
  end

  assign pre_cnt     = pre_ok[3] ? 3'd4 : pre_ok[2] ? 3'd3 : pre_ok[1] ? 3'd2 :
                       pre_ok[0] ? 3'd1 : 3'd0;
  assign since_match = pos_q - mpos_q;

  always_comb begin
    seen_n  = seen_q;
    mpos_n  = mpos_q;
    taken_n = taken_q;
    disp_n  = disp_q;
    ans_n   = answered_q;
    emit    = 1'b0;
    ev_n    = '{status: ST_NOT_FOUND, resolve: 1'b0, pos: mpos_q, disp: disp_q};
    if (!answered_q) begin
      if (seen_q) begin
        if (since_match >= DISP_OFFSET && taken_q < DISP_BYTES) begin
          disp_n  = disp_q | ({24'd0, in_byte_i} << {taken_q[1:0], 3'b000});
          taken_n = taken_q + 3'd1;
        end
      end else if (pos_q >= span_ext && (&hit)) begin
        mpos_n = pos_q - span_ext;
        if (cfg_i.relative_mode) begin
          seen_n  = 1'b1;
          taken_n = pre_cnt;
          disp_n  = pre_val;
        end else begin
          emit  = 1'b1;
          ans_n = 1'b1;
          ev_n  = '{status: ST_FOUND, resolve: 1'b0, pos: mpos_n, disp: disp_n};
        end
      end
      if (seen_n && !ans_n && taken_n >= DISP_BYTES) begin
        emit  = 1'b1;
        ans_n = 1'b1;
        ev_n  = '{status: ST_FOUND, resolve: 1'b1, pos: mpos_n, disp: disp_n};
      end
      if (in_last_i && !ans_n) begin
        emit  = 1'b1;
        ans_n = 1'b1;
        ev_n  = '{status: (seen_n ? ST_CUT : ST_NOT_FOUND), resolve: 1'b0,
                  pos: mpos_n, disp: disp_n};
      end
    end
  end

  always_comb begin
    pos_d      = pos_q;
    seen_d     = seen_q;
    mpos_d     = mpos_q;
    taken_d    = taken_q;
    disp_d     = disp_q;
    answered_d = answered_q;
    ev_d       = ev_q;
    ev_valid_d = ev_valid_q && !ev_ready_i;
    if (s_fire) begin
      ev_valid_d = emit;
      ev_d       = ev_n;
      if (in_last_i) begin
        pos_d      = '0;
        seen_d     = 1'b0;
        mpos_d     = '0;
        taken_d    = '0;
        disp_d     = '0;
        answered_d = 1'b0;
      end else begin
        pos_d      = pos_q + 32'd1;
        seen_d     = seen_n;
        mpos_d     = mpos_n;
        taken_d    = taken_n;
        disp_d     = disp_n;
        answered_d = ans_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      seen_q     <= 1'b0;
      mpos_q     <= '0;
      taken_q    <= '0;
      disp_q     <= '0;
      answered_q <= 1'b0;
      ev_valid_q <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      seen_q     <= seen_d;
      mpos_q     <= mpos_d;
      taken_q    <= taken_d;
      disp_q     <= disp_d;
      answered_q <= answered_d;
      ev_valid_q <= ev_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_q <= ev_d;
  end

  assign ev_valid_o = ev_valid_q;
  assign ev_o       = ev_q;

  `WBSS_ASSERT_IMPL(disp_count_bound, 1'b1, taken_q <= DISP_BYTES)
  `WBSS_ASSERT_NEXT(no_second_answer, s_fire && answered_q, !ev_valid_q)
  `WBSS_ASSERT_NEXT(last_gives_answer, s_fire && in_last_i && !answered_q, ev_valid_q)
  `WBSS_ASSERT_NEXT(event_held, ev_valid_q && !ev_ready_i, ev_valid_q && $stable(ev_q))

endmodule

[hw/rtl/wbss_emit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wbss_emit
// address resolution and the output register of the result stream
// ---------------------------------------------------------------------------
module wbss_emit
  import wbss_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [63:0] image_base_i,
  input  logic        ev_valid_i,
  output logic        ev_ready_o,
  input  event_t      ev_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  out_status_o,
  output logic [63:0] out_addr_o
);

  logic        valid_q, valid_d;
  logic [1:0]  status_q, status_d;
  logic [63:0] addr_q, addr_d;
  logic [63:0] adj;
  logic        load;

  assign ev_ready_o = !valid_q || out_ready_i;
  assign load       = ev_valid_i && ev_ready_o;

  // signed displacement plus the instruction length
  assign adj = ev_i.resolve ? ({{32{ev_i.disp[31]}}, ev_i.disp} + DISP_ADJUST) : 64'd0;

  always_comb begin
    valid_d  = valid_q && !out_ready_i;
    status_d = status_q;
    addr_d   = addr_q;
    if (load) begin
      valid_d  = 1'b1;
      status_d = ev_i.status;
      case (ev_i.status)
        ST_FOUND, ST_CUT: addr_d = image_base_i + {32'd0, ev_i.pos} + adj;
        default:          addr_d = 64'd0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    addr_q   <= addr_d;
  end

  assign out_valid_o  = valid_q;
  assign out_status_o = status_q;
  assign out_addr_o   = addr_q;

endmodule
